### hw/rtl/tpe_pkg.sv
// Shared types, constants and the microcode table of the tape pulse encoder.
package tpe_pkg;

   localparam int BUF_DEPTH = 4096;
   localparam int BUF_AW    = $clog2(BUF_DEPTH);
   localparam int LEN_W     = $clog2(BUF_DEPTH + 1);
   localparam int CSR_IW    = 3;
   localparam int CSR_DW    = 32;

   // Command codes carried in the request tuser
   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_START = 2'd1,
      CMD_PULSE = 2'd2
   } cmd_type;

   // Configuration register indexes
   localparam logic [CSR_IW-1:0] REG_PILOT_PULSE = 3'd0;
   localparam logic [CSR_IW-1:0] REG_SYNC_FIRST  = 3'd1;
   localparam logic [CSR_IW-1:0] REG_SYNC_SECOND = 3'd2;
   localparam logic [CSR_IW-1:0] REG_ZERO_BIT    = 3'd3;
   localparam logic [CSR_IW-1:0] REG_ONE_BIT     = 3'd4;
   localparam logic [CSR_IW-1:0] REG_PILOT_COUNT = 3'd5;
   localparam logic [CSR_IW-1:0] REG_FINAL_BITS  = 3'd6;
   localparam logic [CSR_IW-1:0] REG_PAUSE_TICKS = 3'd7;

   // Step of the microprogram (the block phase)
   typedef enum logic [2:0] {
      PH_DONE  = 3'd0,
      PH_START = 3'd1,
      PH_PILOT = 3'd2,
      PH_SYNC1 = 3'd3,
      PH_SYNC2 = 3'd4,
      PH_DATA  = 3'd5
   } phase_type;

   // Source of the pulse duration
   typedef enum logic [2:0] {
      SRC_NONE  = 3'd0,
      SRC_PILOT = 3'd1,
      SRC_SYNC1 = 3'd2,
      SRC_SYNC2 = 3'd3,
      SRC_BIT   = 3'd4,
      SRC_PAUSE = 3'd5
   } src_type;

   // Jump conditions
   typedef enum logic [1:0] {
      COND_NEVER     = 2'd0,
      COND_LOAD_LAST = 2'd1,
      COND_RUN_LAST  = 2'd2,
      COND_DATA_END  = 2'd3
   } cond_type;

   typedef struct packed {
      src_type   src;
      src_type   jump_src;
      logic      toggle;
      logic      done;
      logic      cnt_load;
      logic      cnt_step;
      logic      bit_step;
      cond_type  cond;
      phase_type jump;
      phase_type next;
   } ucode_word_type;

   // Resolved controls for the datapath
   typedef struct packed {
      src_type src;
      logic    toggle;
      logic    done;
      logic    cnt_load;
      logic    cnt_step;
      logic    bit_step;
   } ctrl_type;

   // Condition flags back from the datapath
   typedef struct packed {
      logic load_last;
      logic run_last;
      logic data_end;
   } flags_type;

   function automatic ucode_word_type ucode_rom(input phase_type ph);
      ucode_word_type w;
      unique case (ph)
         PH_START: w = '{src: SRC_PILOT, jump_src: SRC_PILOT, toggle: 1'b1, done: 1'b0,
                         cnt_load: 1'b1, cnt_step: 1'b1, bit_step: 1'b0,
                         cond: COND_LOAD_LAST, jump: PH_SYNC1, next: PH_PILOT};
         PH_PILOT: w = '{src: SRC_PILOT, jump_src: SRC_PILOT, toggle: 1'b1, done: 1'b0,
                         cnt_load: 1'b0, cnt_step: 1'b1, bit_step: 1'b0,
                         cond: COND_RUN_LAST, jump: PH_SYNC1, next: PH_PILOT};
         PH_SYNC1: w = '{src: SRC_SYNC1, jump_src: SRC_SYNC1, toggle: 1'b1, done: 1'b0,
                         cnt_load: 1'b0, cnt_step: 1'b0, bit_step: 1'b0,
                         cond: COND_NEVER, jump: PH_SYNC2, next: PH_SYNC2};
         PH_SYNC2: w = '{src: SRC_SYNC2, jump_src: SRC_SYNC2, toggle: 1'b1, done: 1'b0,
                         cnt_load: 1'b0, cnt_step: 1'b0, bit_step: 1'b0,
                         cond: COND_NEVER, jump: PH_DATA, next: PH_DATA};
         PH_DATA:  w = '{src: SRC_BIT, jump_src: SRC_PAUSE, toggle: 1'b1, done: 1'b0,
                         cnt_load: 1'b0, cnt_step: 1'b0, bit_step: 1'b1,
                         cond: COND_DATA_END, jump: PH_DONE, next: PH_DATA};
         default:  w = '{src: SRC_NONE, jump_src: SRC_NONE, toggle: 1'b0, done: 1'b1,
                         cnt_load: 1'b0, cnt_step: 1'b0, bit_step: 1'b0,
                         cond: COND_NEVER, jump: PH_DONE, next: PH_DONE};
      endcase
      return w;
   endfunction

endpackage

### hw/rtl/tpe_byte_buffer.sv
// Block byte buffer: one write port, one registered read port.
module tpe_byte_buffer (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [tpe_pkg::BUF_AW-1:0] wr_addr,
   input  logic [7:0]                 wr_data,
   input  logic [tpe_pkg::BUF_AW-1:0] rd_addr,
   output logic [7:0]                 rd_data
);

   logic [7:0] mem [tpe_pkg::BUF_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/tpe_sequencer.sv
// Microcode sequencer: phase step counter, control table lookup and jumps.
module tpe_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  logic                start_en,
   input  logic                start_empty,
   input  logic                start_skip,
   input  logic                step_en,
   input  tpe_pkg::flags_type  flags,
   output tpe_pkg::ctrl_type   ctrl
);

   tpe_pkg::phase_type      phase_ff;
   tpe_pkg::phase_type      phase_in;
   tpe_pkg::ucode_word_type word;
   logic                    taken;

   always_comb begin
      word = tpe_pkg::ucode_rom(phase_ff);
      unique case (word.cond)
         tpe_pkg::COND_LOAD_LAST: taken = flags.load_last;
         tpe_pkg::COND_RUN_LAST:  taken = flags.run_last;
         tpe_pkg::COND_DATA_END:  taken = flags.data_end;
         default:                 taken = 1'b0;
      endcase

      ctrl.src      = taken ? word.jump_src : word.src;
      ctrl.toggle   = word.toggle;
      ctrl.done     = word.done;
      ctrl.cnt_load = word.cnt_load;
      ctrl.cnt_step = word.cnt_step;
      ctrl.bit_step = word.bit_step & ~taken;

      // a start always restarts the program
      priority if (start_en) begin
         if (start_empty) begin
            phase_in = tpe_pkg::PH_DONE;
         end else if (start_skip) begin
            phase_in = tpe_pkg::PH_DATA;
         end else begin
            phase_in = tpe_pkg::PH_START;
         end
      end else if (step_en) begin
         phase_in = taken ? word.jump : word.next;
      end else begin
         phase_in = phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tpe_pkg::PH_DONE;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

### hw/rtl/tape_pulse_encoder_top.sv
// Top level of the tape pulse encoder: stream ports, registers and datapath.
//
//  channel  dir  transaction                 payload
//  req_*    in   load / start / next pulse   tuser: command; tdata: address, byte,
//                                            block length, skip pilot
//  rsp_*    out  one pulse per next-pulse    tdata: pulse_ticks, level; tuser: block_done
//  csr_*    in   register write              index 0..7, data 32 bit
//
// Load and start transactions return nothing. A next-pulse transaction
// sets the block busy: the accept cycle fetches the current byte from
// the buffer read port, then one microcode step runs and fills the
// output register. A full output register stalls only that step; the request
// side stays closed until then. Reset is synchronous and clears the phase (done),
// the counters and the level, and loads the register defaults; no clearing pass is run.
module tape_pulse_encoder_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // [11:0] address, [19:12] data_byte, [32:20] block_length, [33] skip_pilot
   input  logic [39:0]                req_tdata,
   // [1:0] command
   input  logic [1:0]                 req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // [31:0] pulse_ticks, [32] level
   output logic [39:0]                rsp_tdata,
   // [0] block_done
   output logic                       rsp_tuser,
   input  logic                       csr_we,
   input  logic [tpe_pkg::CSR_IW-1:0] csr_index,
   input  logic [tpe_pkg::CSR_DW-1:0] csr_wdata
);

   localparam int LW = tpe_pkg::LEN_W;
   localparam int AW = tpe_pkg::BUF_AW;

   // request fields
   logic [11:0]   req_address;
   logic [7:0]    req_data_byte;
   logic [12:0]   req_block_length;
   logic          req_skip_pilot;
   logic          req_fire;
   logic          do_load;
   logic          do_start;
   logic          do_pulse;

   assign req_address      = req_tdata[11:0];
   assign req_data_byte    = req_tdata[19:12];
   assign req_block_length = req_tdata[32:20];
   assign req_skip_pilot   = req_tdata[33];

   // configuration registers
   logic [15:0] pilot_pulse_ff, sync_first_ff, sync_second_ff;
   logic [15:0] zero_bit_ff, one_bit_ff, pilot_count_ff;
   logic [3:0]  final_bits_ff;
   logic [31:0] pause_ticks_ff;

   // block state
   logic          busy_ff,        busy_in;
   logic [15:0]   pilot_rem_ff,   pilot_rem_in;
   logic [LW-1:0] byte_pos_ff,    byte_pos_in;
   logic [2:0]    bit_index_ff,   bit_index_in;
   logic          second_half_ff, second_half_in;
   logic [LW-1:0] stored_len_ff,  stored_len_in;
   logic          level_ff,       level_in;

   // output register
   logic          rsp_valid_ff,   rsp_valid_in;
   logic [39:0]   rsp_data_ff,    rsp_data_in;
   logic          rsp_user_ff,    rsp_user_in;

   logic               step_fire;
   logic [LW-1:0]      start_len;
   logic [7:0]         rd_byte;
   tpe_pkg::ctrl_type  ctrl;
   tpe_pkg::flags_type flags;
   logic [15:0]        cnt_cur;
   logic [3:0]         next_bit;
   logic               last_byte;
   logic               advance_byte;
   logic [31:0]        ticks;
   logic               buf_we;

   assign req_tready = ~busy_ff;
   assign req_fire   = req_tvalid & req_tready;
   assign do_load    = req_fire & (req_tuser == tpe_pkg::CMD_LOAD);
   assign do_start   = req_fire & (req_tuser == tpe_pkg::CMD_START);
   assign do_pulse   = req_fire & (req_tuser == tpe_pkg::CMD_PULSE);

   // run the step once the output register is free or draining
   assign step_fire  = busy_ff & (~rsp_valid_ff | rsp_tready);

   // saturate the block length to the buffer depth
   assign start_len = (LW'(req_block_length) > LW'(tpe_pkg::BUF_DEPTH)) ?
                      LW'(tpe_pkg::BUF_DEPTH) : LW'(req_block_length);

   // drop loads beyond the buffer
   assign buf_we = do_load & (LW'(req_address) < LW'(tpe_pkg::BUF_DEPTH));

   tpe_byte_buffer u_buffer (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr (AW'(req_address)),
      .wr_data (req_data_byte),
      .rd_addr (byte_pos_ff[AW-1:0]),
      .rd_data (rd_byte)
   );

   assign flags.load_last = (pilot_count_ff <= 16'd1);
   assign flags.run_last  = (pilot_rem_ff <= 16'd1);
   assign flags.data_end  = (byte_pos_ff >= stored_len_ff);

   tpe_sequencer u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .start_en    (do_start),
      .start_empty (start_len == '0),
      .start_skip  (req_skip_pilot),
      .step_en     (step_fire),
      .flags       (flags),
      .ctrl        (ctrl)
   );

   // datapath of one step
   always_comb begin
      cnt_cur      = ctrl.cnt_load ? pilot_count_ff : pilot_rem_ff;
      next_bit     = {1'b0, bit_index_ff} + 4'd1;
      last_byte    = ((byte_pos_ff + LW'(1)) == stored_len_ff);
      advance_byte = next_bit[3] | (last_byte & (next_bit >= final_bits_ff));

      unique case (ctrl.src)
         tpe_pkg::SRC_PILOT: ticks = {16'd0, pilot_pulse_ff};
         tpe_pkg::SRC_SYNC1: ticks = {16'd0, sync_first_ff};
         tpe_pkg::SRC_SYNC2: ticks = {16'd0, sync_second_ff};
         tpe_pkg::SRC_BIT:   ticks = {16'd0, rd_byte[3'd7 - bit_index_ff] ?
                                             one_bit_ff : zero_bit_ff};
         tpe_pkg::SRC_PAUSE: ticks = pause_ticks_ff;
         default:            ticks = 32'd0;
      endcase

      busy_in        = busy_ff;
      pilot_rem_in   = pilot_rem_ff;
      byte_pos_in    = byte_pos_ff;
      bit_index_in   = bit_index_ff;
      second_half_in = second_half_ff;
      stored_len_in  = stored_len_ff;
      level_in       = level_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_user_in    = rsp_user_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_tready;

      if (do_start) begin
         stored_len_in  = start_len;
         byte_pos_in    = '0;
         bit_index_in   = 3'd0;
         second_half_in = 1'b0;
         pilot_rem_in   = 16'd0;
      end

      if (do_pulse) begin
         busy_in = 1'b1;
      end

      if (step_fire) begin
         busy_in  = 1'b0;
         level_in = level_ff ^ ctrl.toggle;
         if (ctrl.cnt_step) begin
            pilot_rem_in = (cnt_cur <= 16'd1) ? 16'd0 : cnt_cur - 16'd1;
         end
         // first half-bit holds the bit, second half advances it
         if (ctrl.bit_step) begin
            if (!second_half_ff) begin
               second_half_in = 1'b1;
            end else begin
               second_half_in = 1'b0;
               if (advance_byte) begin
                  byte_pos_in  = byte_pos_ff + LW'(1);
                  bit_index_in = 3'd0;
               end else begin
                  bit_index_in = next_bit[2:0];
               end
            end
         end
         rsp_valid_in = 1'b1;
         rsp_data_in  = {7'd0, level_in, ticks};
         rsp_user_in  = ctrl.done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         pilot_rem_ff   <= 16'd0;
         byte_pos_ff    <= '0;
         bit_index_ff   <= 3'd0;
         second_half_ff <= 1'b0;
         stored_len_ff  <= '0;
         level_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         busy_ff        <= busy_in;
         pilot_rem_ff   <= pilot_rem_in;
         byte_pos_ff    <= byte_pos_in;
         bit_index_ff   <= bit_index_in;
         second_half_ff <= second_half_in;
         stored_len_ff  <= stored_len_in;
         level_ff       <= level_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pilot_pulse_ff <= 16'd2168;
         sync_first_ff  <= 16'd667;
         sync_second_ff <= 16'd735;
         zero_bit_ff    <= 16'd855;
         one_bit_ff     <= 16'd1710;
         pilot_count_ff <= 16'd8063;
         final_bits_ff  <= 4'd8;
         pause_ticks_ff <= 32'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            tpe_pkg::REG_PILOT_PULSE: pilot_pulse_ff <= csr_wdata[15:0];
            tpe_pkg::REG_SYNC_FIRST:  sync_first_ff  <= csr_wdata[15:0];
            tpe_pkg::REG_SYNC_SECOND: sync_second_ff <= csr_wdata[15:0];
            tpe_pkg::REG_ZERO_BIT:    zero_bit_ff    <= csr_wdata[15:0];
            tpe_pkg::REG_ONE_BIT:     one_bit_ff     <= csr_wdata[15:0];
            tpe_pkg::REG_PILOT_COUNT: pilot_count_ff <= csr_wdata[15:0];
            tpe_pkg::REG_FINAL_BITS:  final_bits_ff  <= csr_wdata[3:0];
            default:                  pause_ticks_ff <= csr_wdata[31:0];
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

### sim/tb_top.sv
// Testbench for the tape pulse encoder: queued stimulus, shadow pulse predictor, result checker.
module tb_top;
   import tpe_pkg::*;

   // Command code the block must ignore without producing a result
   localparam logic [1:0] CMD_UNUSED  = 2'd3;
   // Cycles without any transaction before the run is declared hung
   localparam int         STALL_LIMIT = 3000;
   // Cycles to let a load or start settle after the last result
   localparam int         SETTLE_CYCLES = 4;
   // Length of the one long receiver hold-off
   localparam int         LONG_HOLD = 400;
   // Random transactions per configuration phase
   localparam int         PHASE_ITEMS = 240;

   typedef struct {
      logic [1:0]       cmd;
      logic [11:0]      addr;
      logic [7:0]       data;
      logic [LEN_W-1:0] len;
      logic             skip;
   } tape_req_type;

   typedef struct {
      logic [31:0] ticks;
      logic        level;
      logic        done;
   } tape_pulse_type;

   // DUT ports; every input holds a known value from time zero
   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [39:0]         req_tdata  = '0;
   logic [1:0]          req_tuser  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [39:0]         rsp_tdata;
   logic                rsp_tuser;
   logic                csr_we     = 1'b0;
   logic [CSR_IW-1:0]   csr_index  = '0;
   logic [CSR_DW-1:0]   csr_wdata  = '0;

   tape_pulse_encoder_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Stimulus and checking bookkeeping
   tape_req_type   pending_reqs[$];
   tape_pulse_type expected_pulses[$];
   tape_req_type   cur_req;
   logic        req_taken      = 1'b0;
   int          queued_count   = 0;
   int          error_count    = 0;
   int          quiet_cycles   = 0;
   int          send_idle_pct  = 6;
   int          recv_idle_pct  = 74;
   bit          long_stall_req = 1'b0;
   bit          long_stall_done = 1'b0;
   int          hold_left      = 0;

   // Shadow copy of the timing registers, at their reset values
   logic [15:0] pilot_ticks = 16'd2168;
   logic [15:0] sync1_ticks = 16'd667;
   logic [15:0] sync2_ticks = 16'd735;
   logic [15:0] zero_ticks  = 16'd855;
   logic [15:0] one_ticks   = 16'd1710;
   logic [15:0] pilot_total = 16'd8063;
   logic [3:0]  tail_bits   = 4'd8;
   logic [31:0] pause_len   = 32'd0;

   // Shadow copy of the encoder state
   logic [7:0]  shadow_store [BUF_DEPTH];
   phase_type   shadow_phase = PH_DONE;
   int          pilot_left   = 0;
   int          byte_pos     = 0;
   int          bit_pos      = 0;
   int          blk_len      = 0;
   logic        half_done    = 1'b0;
   logic        shadow_level = 1'b0;

   // Advance the shadow encoder by one accepted transaction; queue the pulse it yields
   task automatic advance_encoder(input tape_req_type r);
      tape_pulse_type p;
      int          next_bit;
      logic [7:0]  cur_byte;
      p = '{ticks: 32'd0, level: 1'b0, done: 1'b0};
      case (r.cmd)
         CMD_LOAD: shadow_store[r.addr] = r.data;
         CMD_START: begin
            // saturate an overlong block to the buffer size
            blk_len    = (int'(r.len) > BUF_DEPTH) ? BUF_DEPTH : int'(r.len);
            byte_pos   = 0;
            bit_pos    = 0;
            half_done  = 1'b0;
            pilot_left = 0;
            if (blk_len == 0)
               shadow_phase = PH_DONE;
            else if (r.skip)
               shadow_phase = PH_DATA;
            else
               shadow_phase = PH_START;
         end
         CMD_PULSE: begin
            if (shadow_phase == PH_START) begin
               pilot_left   = int'(pilot_total);
               shadow_phase = PH_PILOT;
            end
            case (shadow_phase)
               PH_PILOT: begin
                  p.ticks      = {16'd0, pilot_ticks};
                  shadow_level = ~shadow_level;
                  // a zero pilot count still sends one pilot pulse
                  if (pilot_left <= 1) begin
                     pilot_left   = 0;
                     shadow_phase = PH_SYNC1;
                  end else begin
                     pilot_left--;
                  end
               end
               PH_SYNC1: begin
                  p.ticks      = {16'd0, sync1_ticks};
                  shadow_level = ~shadow_level;
                  shadow_phase = PH_SYNC2;
               end
               PH_SYNC2: begin
                  p.ticks      = {16'd0, sync2_ticks};
                  shadow_level = ~shadow_level;
                  shadow_phase = PH_DATA;
               end
               PH_DATA: begin
                  if (byte_pos >= blk_len) begin
                     // closing pause edge
                     shadow_phase = PH_DONE;
                     p.ticks      = pause_len;
                  end else begin
                     cur_byte = shadow_store[byte_pos];
                     p.ticks  = {16'd0, cur_byte[7 - bit_pos] ? one_ticks : zero_ticks};
                     if (!half_done) begin
                        half_done = 1'b1;
                     end else begin
                        half_done = 1'b0;
                        next_bit  = bit_pos + 1;
                        if (next_bit >= 8 ||
                            (byte_pos + 1 == blk_len && next_bit >= int'(tail_bits))) begin
                           byte_pos++;
                           bit_pos = 0;
                        end else begin
                           bit_pos = next_bit;
                        end
                     end
                  end
                  shadow_level = ~shadow_level;
               end
               default: begin
                  // finished block: report done, keep the level
                  shadow_phase = PH_DONE;
                  p.done       = 1'b1;
               end
            endcase
            p.level = shadow_level;
            expected_pulses.push_back(p);
         end
         default: ;
      endcase
   endtask

   // Driver: present the next queued transaction once the current one is taken
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            cur_req = pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {6'd0, cur_req.skip, cur_req.len, cur_req.data, cur_req.addr};
            req_tuser  <= cur_req.cmd;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random back-pressure, plus one long hold-off counted here
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (long_stall_req && !long_stall_done) begin
         long_stall_done <= 1'b1;
         hold_left       <= LONG_HOLD;
         rsp_tready      <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Monitor: check each returned pulse against the oldest prediction, then
   // advance the shadow encoder on each accepted request
   always @(posedge clock) begin : check_pulses
      tape_pulse_type want;
      req_taken <= req_tvalid && req_tready && !reset;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pulses.size() == 0) begin
            $display("%0t: unexpected pulse: ticks %0d level %0b done %0b",
                     $time, rsp_tdata[31:0], rsp_tdata[32], rsp_tuser);
            error_count++;
         end else begin
            want = expected_pulses.pop_front();
            if (rsp_tdata[31:0] !== want.ticks) begin
               $display("%0t: ticks mismatch: expected %0d actual %0d",
                        $time, want.ticks, rsp_tdata[31:0]);
               error_count++;
            end
            if (rsp_tdata[32] !== want.level) begin
               $display("%0t: level mismatch: expected %0b actual %0b",
                        $time, want.level, rsp_tdata[32]);
               error_count++;
            end
            if (rsp_tuser !== want.done) begin
               $display("%0t: block_done mismatch: expected %0b actual %0b",
                        $time, want.done, rsp_tuser);
               error_count++;
            end
         end
      end
      if (!reset && req_tvalid && req_tready)
         advance_encoder(cur_req);
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Append one transaction; ignored commands do not count toward the phase size
   task automatic queue_req(input logic [1:0] cmd, input logic [11:0] addr,
                            input logic [7:0] data, input logic [LEN_W-1:0] len,
                            input logic skip);
      pending_reqs.push_back('{cmd: cmd, addr: addr, data: data, len: len, skip: skip});
      if (cmd != CMD_UNUSED)
         queued_count++;
   endtask

   task automatic queue_pulse();
      queue_req(CMD_PULSE, 12'($urandom), 8'($urandom), LEN_W'($urandom), 1'($urandom));
   endtask

   task automatic queue_start(input logic [LEN_W-1:0] len, input logic skip);
      queue_req(CMD_START, 12'($urandom), 8'($urandom), len, skip);
   endtask

   task automatic queue_load(input logic [11:0] addr, input logic [7:0] data);
      queue_req(CMD_LOAD, addr, data, LEN_W'($urandom), 1'($urandom));
   endtask

   // Noise between pulses: an ignored command or a stray load anywhere
   task automatic queue_noise();
      if ($urandom_range(0, 1) == 0)
         queue_req(CMD_UNUSED, 12'($urandom), 8'($urandom), LEN_W'($urandom), 1'($urandom));
      else
         queue_load(12'($urandom), 8'($urandom));
   endtask

   // One tape block: fill the buffer, start, then request pulses. Most blocks
   // run to done and a little past; some are cut short by the next start.
   // The position at the block end is loaded too, so the block never
   // fetches an entry that was not written.
   task automatic queue_tape_block();
      int   n_bytes;
      int   pre;
      int   fb;
      int   full;
      int   n_pulses;
      int   lead;
      logic skip;
      n_bytes = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
      for (int i = 0; i <= n_bytes; i++)
         queue_load(12'(i), 8'($urandom));
      if ($urandom_range(0, 9) == 0) begin
         queue_start('0, 1'($urandom));
         queue_pulse();
      end
      skip = 1'($urandom_range(0, 1));
      fb   = (tail_bits == 4'd0) ? 1 : ((tail_bits > 4'd8) ? 8 : int'(tail_bits));
      pre  = skip ? 0 : (((pilot_total == 16'd0) ? 1 : int'(pilot_total)) + 2);
      full = pre + 2 * ((n_bytes - 1) * 8 + fb) + 1;
      lead = (pre > 40) ? 40 : pre;
      if ($urandom_range(0, 7) == 0) begin
         // longer block than loaded: stop before leaving the loaded bytes
         queue_start(LEN_W'($urandom_range(n_bytes + 1, 8191)), skip);
         n_pulses = $urandom_range(1, lead + 16 * n_bytes);
      end else begin
         queue_start(LEN_W'(n_bytes), skip);
         if (pre > 40 || $urandom_range(0, 9) == 0)
            n_pulses = $urandom_range(1, (pre > 40) ? lead : full);
         else
            n_pulses = full + $urandom_range(0, 2);
      end
      repeat (n_pulses) begin
         if ($urandom_range(0, 15) == 0)
            queue_noise();
         queue_pulse();
      end
   endtask

   task automatic queue_random_phase();
      int base;
      base = queued_count;
      while (queued_count - base < PHASE_ITEMS)
         queue_tape_block();
   endtask

   // Wait until everything queued is accepted and every pulse has come back
   task automatic wait_quiet();
      do
         @(posedge clock);
      while (pending_reqs.size() != 0 || req_tvalid || expected_pulses.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register and update the shadow copy
   task automatic write_reg(input logic [CSR_IW-1:0] idx, input logic [CSR_DW-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         REG_PILOT_PULSE: pilot_ticks = value[15:0];
         REG_SYNC_FIRST:  sync1_ticks = value[15:0];
         REG_SYNC_SECOND: sync2_ticks = value[15:0];
         REG_ZERO_BIT:    zero_ticks  = value[15:0];
         REG_ONE_BIT:     one_ticks   = value[15:0];
         REG_PILOT_COUNT: pilot_total = value[15:0];
         REG_FINAL_BITS:  tail_bits   = value[3:0];
         REG_PAUSE_TICKS: pause_len   = value;
         default: ;
      endcase
   endtask

   // Program all timing registers; garbage puts random bits above each field but the full-width pause
   task automatic program_regs(input logic [15:0] pp, input logic [15:0] s1,
                               input logic [15:0] s2, input logic [15:0] zb,
                               input logic [15:0] ob, input logic [15:0] pc,
                               input logic [3:0] fb, input logic [31:0] pause,
                               input bit garbage);
      logic [31:0] hi;
      hi = garbage ? $urandom : 32'd0;
      write_reg(REG_PILOT_PULSE, {hi[31:16], pp});
      write_reg(REG_SYNC_FIRST,  {hi[15:0],  s1});
      write_reg(REG_SYNC_SECOND, {hi[31:16], s2});
      write_reg(REG_ZERO_BIT,    {hi[15:0],  zb});
      write_reg(REG_ONE_BIT,     {hi[31:16], ob});
      write_reg(REG_PILOT_COUNT, {hi[15:0],  pc});
      write_reg(REG_FINAL_BITS,  {hi[31:4],  fb});
      write_reg(REG_PAUSE_TICKS, pause);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      // Hold reset, then release it at a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at reset timing. Load first so no fetch sees an
      // unwritten entry.
      queue_load(12'd0, 8'hA5);
      queue_load(12'd1, 8'h00);
      queue_load(12'hFFF, 8'h5A);
      // request while done after reset: done, no toggle
      queue_pulse();
      // ignored command with every field bit set
      queue_req(CMD_UNUSED, 12'hFFF, 8'hFF, 13'h1FFF, 1'b1);
      // empty block goes straight to done
      queue_start(13'd0, 1'b0);
      queue_pulse();
      // overlong block with pilot: a few pilot pulses, then restart
      queue_start(13'h1FFF, 1'b0);
      repeat (3) queue_pulse();
      // restart while running keeps the level; one pure data byte to done
      queue_start(13'd1, 1'b1);
      repeat (18) queue_pulse();
      wait_quiet();

      // Sender idles rarely, receiver often
      program_regs(16'd0, 16'hFFFF, 16'd1, 16'd0, 16'hFFFF, 16'd1, 4'd1,
                   32'hFFFF_FFFF, 1'b0);
      queue_random_phase();
      wait_quiet();

      // zero pilot count and zero final bits, junk above each field
      program_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'd0, 4'd0, $urandom, 1'b1);
      queue_random_phase();
      wait_quiet();

      // Swap: sender idles often, receiver rarely
      send_idle_pct = 74;
      recv_idle_pct = 6;
      program_regs(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 4'd15,
                   32'd0, 1'b0);
      queue_random_phase();
      wait_quiet();

      program_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom_range(2, 6)), 4'($urandom_range(1, 8)),
                   $urandom, 1'b0);
      queue_random_phase();
      wait_quiet();

      // No idling; hold the receiver off once so the block backs up
      send_idle_pct = 0;
      recv_idle_pct = 0;
      program_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'd3, 4'd8, $urandom, 1'b0);
      long_stall_req = 1'b1;
      queue_random_phase();
      wait_quiet();

      if (error_count == 0 && expected_pulses.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
